/* hw/rtl/ocfr_pkg.sv */
// Package with the shared types and codes of the offset chunk frame reassembler.
package ocfr_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_COPY_RD,
        S_COPY_WR,
        S_ADVANCE,
        S_EMIT,
        S_PUB_RD,
        S_PUB_OUT
    } t_state;

    // Chunk status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_IDLE_RST  = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT = 3'd2;
    localparam logic [2:0] ST_DISCARD   = 3'd3;
    localparam logic [2:0] ST_PUBLISH   = 3'd4;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    // Byte that marks an idle link
    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    // Shortest chunk that carries data
    localparam int MIN_DATA_LEN = 2;

endpackage

/* hw/rtl/ocfr_if.sv */
// Valid/ready channel interfaces for link bytes in and results out.
interface ocfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_chunk;

    modport source (output valid, output data_byte, output byte_valid, output end_of_chunk,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input end_of_chunk,
                    output ready);
endinterface

interface ocfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  status;
    logic [4:0]  byte_index;
    logic [7:0]  frame_byte;
    logic [7:0]  previous_byte;
    logic        last;
    logic [31:0] bytes_received;

    modport source (output valid, output kind, output status, output byte_index,
                    output frame_byte, output previous_byte, output last,
                    output bytes_received, input ready);
    modport sink   (input valid, input kind, input status, input byte_index,
                    input frame_byte, input previous_byte, input last,
                    input bytes_received, output ready);
endinterface

/* hw/rtl/offset_chunk_frame_reassembler.sv */
// Top level of the offset chunk frame reassembler: staging, copy sequencer and output stage.
//
// Usage: link bytes enter on i_in, one per transfer; byte_valid = 0 makes a bare end mark,
// and end_of_chunk = 1 closes the chunk after that transfer. Results leave on o_out.
// A transfer that does not close a chunk gives no result.
// A closing transfer starts the sequencer: it classifies the chunk, copies each byte into the
// assembly buffer (one chunk RAM read, one assembly RAM write), advances the assembly offset,
// then gives the status result; idle and too-short chunks skip the copy and the advance.
// A published frame follows the status with FRAME_BYTES frame byte results, each a RAM read,
// then an output load, during which the current frame is rewritten from the assembly buffer.
// i_in.ready stays low from the closing transfer until the sequencer is back in idle.
// The one output register lets the next result wait while the receiver stalls; the sequencer
// holds until the register frees up, and it may accept new bytes while the final result waits.
// Reset (i_rst_n low at a clock edge) clears the counters, the assembly offset and the valid bits of
// the assembly and current frame stores, so all frames read as zeros until written.
module offset_chunk_frame_reassembler #(
    parameter int CHUNK_BYTES = 32,
    parameter int FRAME_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ocfr_in_if.sink           i_in,
    ocfr_out_if.source        o_out
);
    localparam int CAW   = $clog2(CHUNK_BYTES);
    localparam int CW    = $clog2(CHUNK_BYTES + 1);
    localparam int FAW   = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int MAXN  = (CHUNK_BYTES > FRAME_BYTES) ? CHUNK_BYTES : FRAME_BYTES;
    localparam int IW    = $clog2(MAXN + 1);

    ocfr_pkg::t_state r_state, n_state;

    logic [CW-1:0]          r_chunk_len;
    logic                   r_all_ones;
    logic [7:0]             r_offset;
    logic [6:0]             r_asm_off;
    logic                   r_first_seen;
    logic [31:0]            r_counter;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_copy_n;
    logic [2:0]             r_status;
    logic [FRAME_BYTES-1:0] r_asm_vld;
    logic [FRAME_BYTES-1:0] r_cur_vld;

    logic                   r_ov;
    logic                   r_o_kind;
    logic [2:0]             r_o_status;
    logic [4:0]             r_o_idx;
    logic [7:0]             r_o_fb;
    logic [7:0]             r_o_pb;
    logic                   r_o_last;
    logic [31:0]            r_o_cnt;

    logic                   w_accept;
    logic                   w_store;
    logic                   w_slot;
    logic                   w_in_ready;
    logic                   w_load_st;
    logic                   w_load_fb;
    logic                   w_asm_we;
    logic [7:0]             w_len8;
    logic [7:0]             w_len_m1;
    logic [7:0]             w_room;
    logic [7:0]             w_n8;
    logic [6:0]             w_adv;
    logic                   w_copy_end;
    logic                   w_pub_last;
    logic [FAW-1:0]         w_fidx;
    logic [FAW-1:0]         w_asm_waddr;
    logic [CAW-1:0]         w_chunk_raddr;
    logic [7:0]             w_chunk_rdata;
    logic [7:0]             w_asm_rdata;
    logic [7:0]             w_cur_rdata;
    logic [7:0]             w_fb;
    logic [7:0]             w_pb;

    // Handshake and shared datapath terms
    assign w_accept      = i_in.valid && w_in_ready;
    assign w_store       = w_accept && i_in.byte_valid && (r_chunk_len < CW'(CHUNK_BYTES));
    assign w_slot        = !r_ov || o_out.ready;
    assign w_len8        = 8'(r_chunk_len);
    assign w_len_m1      = w_len8 - 8'd1;
    assign w_room        = 8'(FRAME_BYTES) - r_offset;
    assign w_n8          = (r_offset >= 8'(FRAME_BYTES)) ? 8'd0 :
                           ((w_len_m1 < w_room) ? w_len_m1 : w_room);
    assign w_adv         = r_asm_off + 7'(r_copy_n);
    assign w_copy_end    = (r_idx + IW'(1)) == r_copy_n;
    assign w_pub_last    = r_idx == IW'(FRAME_BYTES - 1);
    assign w_fidx        = r_idx[FAW-1:0];
    assign w_asm_waddr   = FAW'(r_offset) + FAW'(r_idx);
    assign w_chunk_raddr = CAW'(r_idx + IW'(1));
    assign w_fb          = r_asm_vld[w_fidx] ? w_asm_rdata : 8'd0;
    assign w_pb          = r_cur_vld[w_fidx] ? w_cur_rdata : 8'd0;

    // Chunk staging store
    ocfr_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_chunk_len[CAW-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (w_chunk_raddr),
        .o_rdata (w_chunk_rdata)
    );

    // Assembly buffer
    ocfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_asm_ram (
        .i_clk   (i_clk),
        .i_we    (w_asm_we),
        .i_waddr (w_asm_waddr),
        .i_wdata (w_chunk_rdata),
        .i_raddr (w_fidx),
        .o_rdata (w_asm_rdata)
    );

    // Current frame store; the previous frame is its old contents, read out as rewritten
    ocfr_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_fb),
        .i_waddr (w_fidx),
        .i_wdata (w_fb),
        .i_raddr (w_fidx),
        .o_rdata (w_cur_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ocfr_pkg::S_IDLE: begin
                if (w_accept && i_in.end_of_chunk) begin
                    n_state = ocfr_pkg::S_CLASS;
                end
            end
            ocfr_pkg::S_CLASS: begin
                if (r_all_ones || (r_chunk_len < CW'(ocfr_pkg::MIN_DATA_LEN))) begin
                    n_state = ocfr_pkg::S_EMIT;
                end else if (w_n8 != 8'd0) begin
                    n_state = ocfr_pkg::S_COPY_RD;
                end else begin
                    n_state = ocfr_pkg::S_ADVANCE;
                end
            end
            ocfr_pkg::S_COPY_RD: begin
                n_state = ocfr_pkg::S_COPY_WR;
            end
            ocfr_pkg::S_COPY_WR: begin
                n_state = w_copy_end ? ocfr_pkg::S_ADVANCE : ocfr_pkg::S_COPY_RD;
            end
            ocfr_pkg::S_ADVANCE: begin
                n_state = ocfr_pkg::S_EMIT;
            end
            ocfr_pkg::S_EMIT: begin
                if (w_slot) begin
                    n_state = (r_status == ocfr_pkg::ST_PUBLISH) ? ocfr_pkg::S_PUB_RD
                                                                 : ocfr_pkg::S_IDLE;
                end
            end
            ocfr_pkg::S_PUB_RD: begin
                n_state = ocfr_pkg::S_PUB_OUT;
            end
            ocfr_pkg::S_PUB_OUT: begin
                if (w_slot) begin
                    n_state = w_pub_last ? ocfr_pkg::S_IDLE : ocfr_pkg::S_PUB_RD;
                end
            end
            default: begin
                n_state = ocfr_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_asm_we   = 1'b0;
        w_load_st  = 1'b0;
        w_load_fb  = 1'b0;
        case (r_state)
            ocfr_pkg::S_IDLE:    w_in_ready = 1'b1;
            ocfr_pkg::S_COPY_WR: w_asm_we   = 1'b1;
            ocfr_pkg::S_EMIT:    w_load_st  = w_slot;
            ocfr_pkg::S_PUB_OUT: w_load_fb  = w_slot;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ocfr_pkg::S_IDLE;
            r_chunk_len  <= '0;
            r_all_ones   <= 1'b1;
            r_asm_off    <= '0;
            r_first_seen <= 1'b0;
            r_counter    <= '0;
            r_asm_vld    <= '0;
            r_cur_vld    <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;

            // Stage a byte of the open chunk
            if (w_store) begin
                r_chunk_len <= r_chunk_len + CW'(1);
                if (i_in.data_byte != ocfr_pkg::IDLE_BYTE) begin
                    r_all_ones <= 1'b0;
                end
            end

            // Close the chunk and classify it
            if (r_state == ocfr_pkg::S_CLASS) begin
                r_chunk_len <= '0;
                r_all_ones  <= 1'b1;
                if (r_all_ones) begin
                    r_asm_off <= '0;
                    r_counter <= r_counter + 32'd1;
                end else begin
                    r_counter <= r_counter + 32'(r_chunk_len);
                end
            end

            // Mark written assembly bytes
            if (w_asm_we) begin
                r_asm_vld[w_asm_waddr] <= 1'b1;
            end

            // Advance the assembly offset; a full frame clears it
            if (r_state == ocfr_pkg::S_ADVANCE) begin
                if (w_adv < 7'(FRAME_BYTES)) begin
                    r_asm_off <= w_adv;
                end else begin
                    r_asm_off    <= '0;
                    r_first_seen <= 1'b1;
                end
            end

            if (w_load_fb) begin
                r_cur_vld[w_fidx] <= 1'b1;
            end

            // Output register occupancy
            if (w_load_st || w_load_fb) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Keep the write offset from the first byte of the chunk
        if (w_store && (r_chunk_len == '0)) begin
            r_offset <= i_in.data_byte;
        end

        // Loop index and count
        case (r_state)
            ocfr_pkg::S_CLASS: begin
                r_idx    <= '0;
                r_copy_n <= IW'(w_n8);
                if (r_all_ones) begin
                    r_status <= ocfr_pkg::ST_IDLE_RST;
                end else begin
                    r_status <= ocfr_pkg::ST_TOO_SHORT;
                end
            end
            ocfr_pkg::S_COPY_WR: begin
                r_idx <= r_idx + IW'(1);
            end
            ocfr_pkg::S_ADVANCE: begin
                r_idx <= '0;
                if (w_adv < 7'(FRAME_BYTES)) begin
                    r_status <= ocfr_pkg::ST_ACCEPTED;
                end else if (!r_first_seen) begin
                    r_status <= ocfr_pkg::ST_DISCARD;
                end else begin
                    r_status <= ocfr_pkg::ST_PUBLISH;
                end
            end
            ocfr_pkg::S_PUB_OUT: begin
                if (w_slot) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase

        // Load the output register
        if (w_load_st) begin
            r_o_kind   <= ocfr_pkg::KIND_STATUS;
            r_o_status <= r_status;
            r_o_idx    <= '0;
            r_o_fb     <= '0;
            r_o_pb     <= '0;
            r_o_last   <= (r_status != ocfr_pkg::ST_PUBLISH);
            r_o_cnt    <= r_counter;
        end else if (w_load_fb) begin
            r_o_kind   <= ocfr_pkg::KIND_FRAME;
            r_o_status <= ocfr_pkg::ST_PUBLISH;
            r_o_idx    <= 5'(r_idx);
            r_o_fb     <= w_fb;
            r_o_pb     <= w_pb;
            r_o_last   <= w_pub_last;
            r_o_cnt    <= r_counter;
        end
    end

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = r_ov;
    assign o_out.kind           = r_o_kind;
    assign o_out.status         = r_o_status;
    assign o_out.byte_index     = r_o_idx;
    assign o_out.frame_byte     = r_o_fb;
    assign o_out.previous_byte  = r_o_pb;
    assign o_out.last           = r_o_last;
    assign o_out.bytes_received = r_o_cnt;

`ifndef SYNTHESIS
    // Assembly offset never rests at or past a full frame
    a_asm_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_asm_off < 7'(FRAME_BYTES))
        else $error("assembly offset out of range");

    // Copy writes stay inside the frame
    a_copy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ocfr_pkg::S_COPY_WR) |-> ((9'(r_offset) + 9'(r_idx)) < 9'(FRAME_BYTES)))
        else $error("assembly write past frame end");

    // Staged length never exceeds the chunk size
    a_chunk_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_len <= CW'(CHUNK_BYTES))
        else $error("chunk length overflow");

    // A result is loaded only while the output slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_st || w_load_fb) |-> (!r_ov || o_out.ready))
        else $error("output register overwritten");
`endif
endmodule

/* hw/rtl/ocfr_ram.sv */
// Generic single write port RAM with one registered read port.
module ocfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench of the offset chunk frame reassembler: directed and random chunks, each result checked.
module tb;

    localparam int CHUNK_BYTES  = 32;
    localparam int FRAME_BYTES  = 32;
    localparam int RANDOM_ITEMS = 380;
    localparam int PRINT_LIMIT  = 40;

    // One result as the block should present it
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [4:0]  byte_index;
        logic [7:0]  frame_byte;
        logic [7:0]  previous_byte;
        logic        last;
        logic [31:0] bytes_received;
    } t_result;

    // Receiver stall patterns
    typedef enum logic [2:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_COMB,
        RX_BLOCK
    } t_rx_pattern;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ocfr_in_if  link_ch ();
    ocfr_out_if res_ch ();

    offset_chunk_frame_reassembler #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (link_ch),
        .o_out   (res_ch)
    );

    // Predicted state of the reassembler
    logic [7:0]  stage_bytes [CHUNK_BYTES];
    int unsigned stage_len;
    logic        stage_all_idle;
    logic [7:0]  asm_buf    [FRAME_BYTES];
    logic [6:0]  asm_off;
    logic [7:0]  cur_frame  [FRAME_BYTES];
    logic [7:0]  prev_frame [FRAME_BYTES];
    logic        frame_seen;
    logic [31:0] rx_count;

    t_result     pending_results [$];
    int          err_count    = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    int          results_seen = 0;

    logic [5:0]  stall_phase = '0;
    t_rx_pattern rx_pattern  = RX_STEADY;

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold the result channel on a changing stall pattern
    always @(posedge clk) begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == 6'd63) begin
            rx_pattern <= t_rx_pattern'($urandom_range(0, 4));
        end
        case (rx_pattern)
            RX_STEADY: res_ch.ready <= 1'b1;
            RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
            RX_COMB:   res_ch.ready <= (stall_phase[2:0] != 3'd0);
            default:   res_ch.ready <= (stall_phase >= 6'd48);
        endcase
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    function automatic void clear_frame_model();
        stage_len      = 0;
        stage_all_idle = 1'b1;
        asm_off        = '0;
        frame_seen     = 1'b0;
        rx_count       = '0;
        foreach (stage_bytes[i]) stage_bytes[i] = '0;
        foreach (asm_buf[i]) begin
            asm_buf[i]    = '0;
            cur_frame[i]  = '0;
            prev_frame[i] = '0;
        end
    endfunction

    function automatic void queue_result(logic kind, logic [2:0] status, logic [4:0] idx,
                                         logic [7:0] fb, logic [7:0] pb, logic last);
        t_result r;
        r.kind           = kind;
        r.status         = status;
        r.byte_index     = idx;
        r.frame_byte     = fb;
        r.previous_byte  = pb;
        r.last           = last;
        r.bytes_received = rx_count;
        pending_results.push_back(r);
    endfunction

    // Advance the predicted state by one link transfer and queue what it causes
    function automatic void predict_link_byte(logic [7:0] b, logic bv, logic eoc);
        int unsigned nbytes;
        int unsigned off;
        int unsigned n;
        if (bv && stage_len < CHUNK_BYTES) begin
            stage_bytes[stage_len] = b;
            stage_len++;
            if (b != ocfr_pkg::IDLE_BYTE) stage_all_idle = 1'b0;
        end
        if (!eoc) return;
        nbytes    = stage_len;
        stage_len = 0;

        // Empty or all-idle chunk: restart assembly, count one byte
        if (stage_all_idle) begin
            asm_off  = '0;
            rx_count = rx_count + 32'd1;
            queue_result(ocfr_pkg::KIND_STATUS, ocfr_pkg::ST_IDLE_RST, '0, '0, '0, 1'b1);
            return;
        end
        stage_all_idle = 1'b1;
        rx_count       = rx_count + nbytes;

        if (nbytes < ocfr_pkg::MIN_DATA_LEN) begin
            queue_result(ocfr_pkg::KIND_STATUS, ocfr_pkg::ST_TOO_SHORT, '0, '0, '0, 1'b1);
            return;
        end

        // Write the payload at the offset, clipped at the frame end
        off = stage_bytes[0];
        n   = nbytes - 1;
        if (off >= FRAME_BYTES) n = 0;
        else if (off + n > FRAME_BYTES) n = FRAME_BYTES - off;
        for (int i = 0; i < n; i++) asm_buf[off + i] = stage_bytes[1 + i];
        asm_off = asm_off + n[6:0];

        if (asm_off < FRAME_BYTES) begin
            queue_result(ocfr_pkg::KIND_STATUS, ocfr_pkg::ST_ACCEPTED, '0, '0, '0, 1'b1);
            return;
        end
        asm_off = '0;

        if (!frame_seen) begin
            frame_seen = 1'b1;
            queue_result(ocfr_pkg::KIND_STATUS, ocfr_pkg::ST_DISCARD, '0, '0, '0, 1'b1);
            return;
        end

        // Rotate frames and stream the new one
        prev_frame = cur_frame;
        cur_frame  = asm_buf;
        queue_result(ocfr_pkg::KIND_STATUS, ocfr_pkg::ST_PUBLISH, '0, '0, '0, 1'b0);
        for (int i = 0; i < FRAME_BYTES; i++) begin
            queue_result(ocfr_pkg::KIND_FRAME, ocfr_pkg::ST_PUBLISH, i[4:0],
                         cur_frame[i], prev_frame[i], i == FRAME_BYTES - 1);
        end
    endfunction

    // Send one link transfer in bursts with random gaps between them
    task automatic send_link_item(input logic [7:0] b, input logic bv, input logic eoc);
        int   gap;
        logic took;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                link_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        link_ch.valid        <= 1'b1;
        link_ch.data_byte    <= b;
        link_ch.byte_valid   <= bv;
        link_ch.end_of_chunk <= eoc;
        do begin
            @(negedge clk);
            took = link_ch.ready;
            @(posedge clk);
        end while (!took);
        predict_link_byte(b, bv, eoc);
        items_sent++;
    endtask

    // Send a chunk body, closing on the last byte or with a bare end mark
    task automatic send_chunk(input logic [7:0] body [$], input logic bare_close);
        logic close_bare;
        close_bare = bare_close || (body.size() == 0);
        foreach (body[i]) begin
            if ($urandom_range(0, 9) == 0) begin
                send_link_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_link_item(body[i], 1'b1, !close_bare && i == body.size() - 1);
        end
        if (close_bare) begin
            send_link_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Pause the link until every expected result has come
    task automatic wait_results_drained();
        link_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_idle_chunks();
        logic [7:0] body [$];
        body = {};
        send_chunk(body, 1'b1);
        body = {8'hFF, 8'hFF, 8'hFF};
        send_chunk(body, 1'b0);
        send_link_item(8'h5A, 1'b0, 1'b0);
        body = {8'hFF};
        send_chunk(body, 1'b0);
        wait_results_drained();
    endtask

    task automatic test_short_chunks();
        logic [7:0] body [$];
        body = {8'h00};
        send_chunk(body, 1'b0);
        body = {8'h80};
        send_chunk(body, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_offset_limits();
        logic [7:0] body [$];
        // Offset just past the frame and at the top of the byte range
        body = {8'h20, 8'hAA, 8'h55};
        send_chunk(body, 1'b0);
        body = {8'hFF, 8'h01};
        send_chunk(body, 1'b0);
        // Clip at the frame end, then a small write at the start
        body = {8'h1E, 8'h11, 8'h22, 8'h33};
        send_chunk(body, 1'b0);
        body = {8'h00, 8'hFE};
        send_chunk(body, 1'b1);
        body = {8'h7F, 8'h7F};
        send_chunk(body, 1'b0);
        wait_results_drained();
    endtask

    // Mostly data chunks that fill frames, mixed with idle, short and noisy chunks
    task automatic test_random_frames();
        logic [7:0] body [$];
        int         start;
        int         pick;
        int         len;
        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            body = {};
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                body.push_back(($urandom_range(0, 9) == 0) ?
                               8'($urandom_range(FRAME_BYTES, 255)) :
                               8'($urandom_range(0, FRAME_BYTES - 1)));
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(CHUNK_BYTES, CHUNK_BYTES + 8)
                                                  : $urandom_range(1, CHUNK_BYTES - 1);
                repeat (len) body.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 77) begin
                repeat ($urandom_range(0, 3)) body.push_back(ocfr_pkg::IDLE_BYTE);
            end else if (pick < 87) begin
                body.push_back(8'($urandom_range(0, 254)));
            end else begin
                repeat ($urandom_range(0, 8)) begin
                    body.push_back(($urandom_range(0, 1) == 0) ? ocfr_pkg::IDLE_BYTE
                                                               : 8'($urandom_range(0, 255)));
                end
            end
            send_chunk(body, 1'($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 19) == 0) wait_results_drained();
        end
        wait_results_drained();
    endtask

    // Compare each result with the oldest expectation
    initial begin : result_checker
        logic    took;
        t_result got;
        t_result want;
        forever begin
            @(negedge clk);
            took               = rst_n && res_ch.valid && res_ch.ready;
            got.kind           = res_ch.kind;
            got.status         = res_ch.status;
            got.byte_index     = res_ch.byte_index;
            got.frame_byte     = res_ch.frame_byte;
            got.previous_byte  = res_ch.previous_byte;
            got.last           = res_ch.last;
            got.bytes_received = res_ch.bytes_received;
            @(posedge clk);
            if (took) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("byte_index", 32'(got.byte_index), 32'(want.byte_index));
                    check_field("frame_byte", 32'(got.frame_byte), 32'(want.frame_byte));
                    check_field("previous_byte", 32'(got.previous_byte),
                                32'(want.previous_byte));
                    check_field("last", 32'(got.last), 32'(want.last));
                    check_field("bytes_received", got.bytes_received, want.bytes_received);
                end
            end
        end
    end

    // Run limit
    initial begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Reset, then run the tests in turn
    initial begin
        link_ch.valid        = 1'b0;
        link_ch.data_byte    = '0;
        link_ch.byte_valid   = 1'b0;
        link_ch.end_of_chunk = 1'b0;
        res_ch.ready         = 1'b0;
        clear_frame_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_chunks();
        test_short_chunks();
        test_offset_limits();
        test_random_frames();

        // Catch stray results after the last expectation
        repeat (200) @(posedge clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
